// ===== rtl/hem_pkg.sv =====
// Shared constants, codes and types for the HDR exposure merge block.
package hem_pkg;

  localparam int SAMPLE_BITS  = 8;
  localparam int LINEAR_BITS  = 20;
  localparam int CHANNEL_BITS = 2;
  localparam int NUM_CHANNELS = 3;
  localparam int GAIN_BITS    = 16;
  localparam int GAIN_FRAC    = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;

  localparam int CODES       = 1 << SAMPLE_BITS;
  localparam int TABLE_DEPTH = NUM_CHANNELS * CODES;
  localparam int ADDR_BITS   = CHANNEL_BITS + SAMPLE_BITS;

  // Linear value times Q0.16 gain, plus the half-LSB rounding term.
  localparam int PROD_BITS = LINEAR_BITS + GAIN_BITS;
  localparam logic [PROD_BITS-1:0] GAIN_ROUND = PROD_BITS'(1) << (GAIN_FRAC - 1);

  // Three-way average: floor((sum + 1) / 3) by reciprocal multiply.
  localparam int SUM_BITS   = LINEAR_BITS + 2;
  localparam int DIV3_SHIFT = SUM_BITS + 2;
  localparam int DIV3_BITS  = DIV3_SHIFT - 1;
  localparam logic [63:0] DIV3_RECIP_FULL = ((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3;
  localparam logic [DIV3_BITS-1:0] DIV3_RECIP = DIV3_RECIP_FULL[DIV3_BITS-1:0];
  localparam int DIV3_PROD_BITS = SUM_BITS + DIV3_BITS;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [GAIN_BITS-1:0]   GAIN_RESET = '1;
  localparam logic [SAMPLE_BITS-1:0] SAT_RESET  = '1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_MERGE = 1'b1
  } op_t;

  typedef enum logic {
    MODE_PICK    = 1'b0,
    MODE_AVERAGE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    SRC_SHORT = 2'd0,
    SRC_MID   = 2'd1,
    SRC_LONG  = 2'd2
  } source_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MERGE_MODE = 2'd0,
    CFG_GAIN_MID   = 2'd1,
    CFG_GAIN_LONG  = 2'd2,
    CFG_SAT_LEVEL  = 2'd3
  } cfg_index_t;

  typedef struct packed {
    mode_t                  merge_mode;
    logic [GAIN_BITS-1:0]   gain_mid;
    logic [GAIN_BITS-1:0]   gain_long;
    logic [SAMPLE_BITS-1:0] sat_level;
  } cfg_t;

  // One classified item as it sits in the queue.
  typedef struct packed {
    logic                   is_load;
    logic                   ch_ok;
    logic                   long_ok;
    logic                   mid_ok;
    logic [ADDR_BITS-1:0]   addr_s;   // write address for loads
    logic [ADDR_BITS-1:0]   addr_m;
    logic [ADDR_BITS-1:0]   addr_l;
    logic [LINEAR_BITS-1:0] value;
  } cmd_t;

endpackage

// ===== rtl/hem_front.sv =====
// Front end: classifies an input item into a queue command.
module hem_front (
  input  logic                             op,
  input  logic [hem_pkg::CHANNEL_BITS-1:0] channel,
  input  logic [hem_pkg::SAMPLE_BITS-1:0]  table_index,
  input  logic [hem_pkg::LINEAR_BITS-1:0]  table_value,
  input  logic [hem_pkg::SAMPLE_BITS-1:0]  sample_short,
  input  logic [hem_pkg::SAMPLE_BITS-1:0]  sample_mid,
  input  logic [hem_pkg::SAMPLE_BITS-1:0]  sample_long,
  input  hem_pkg::cfg_t                    cfg,
  output hem_pkg::cmd_t                    cmd
);
  import hem_pkg::*;

  logic                    ch_ok;
  logic [CHANNEL_BITS-1:0] ch_base;
  logic                    is_load;

  always_comb begin
    is_load = (op == OP_LOAD);
    ch_ok   = (channel < CHANNEL_BITS'(NUM_CHANNELS));
    // Channel three never addresses the table; point it at channel zero.
    ch_base = ch_ok ? channel : '0;

    cmd.is_load = is_load;
    cmd.ch_ok   = ch_ok;
    cmd.long_ok = (sample_long < cfg.sat_level);
    cmd.mid_ok  = (sample_mid < cfg.sat_level);
    cmd.addr_s  = {ch_base, (is_load ? table_index : sample_short)};
    cmd.addr_m  = {ch_base, sample_mid};
    cmd.addr_l  = {ch_base, sample_long};
    cmd.value   = table_value;
  end

endmodule

// ===== rtl/hem_queue.sv =====
// Short command queue between the front end and the merge pipeline.
module hem_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hem_pkg::cmd_t push_data,
  input  logic          pop,
  output hem_pkg::cmd_t head,
  output logic          not_empty,
  output logic          full
);
  import hem_pkg::*;

  cmd_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == (QPTR_BITS + 1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/hem_back.sv =====
// Back end: table storage, gain scaling, exposure selection and averaging.
module hem_back (
  input  logic                             clk,
  input  logic                             rst,
  input  hem_pkg::cfg_t                    cfg,
  input  hem_pkg::cmd_t                    head,
  input  logic                             not_empty,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [hem_pkg::LINEAR_BITS-1:0]  radiance,
  output logic [1:0]                       source
);
  import hem_pkg::*;

  logic adv;
  logic wr_en;

  // Three copies of the table, one read port each.
  logic [LINEAR_BITS-1:0] mem_s [TABLE_DEPTH];
  logic [LINEAR_BITS-1:0] mem_m [TABLE_DEPTH];
  logic [LINEAR_BITS-1:0] mem_l [TABLE_DEPTH];

  // Stage 1: table read
  logic                   s1_valid;
  logic                   s1_ch_ok;
  logic                   s1_long_ok;
  logic                   s1_mid_ok;
  logic [LINEAR_BITS-1:0] rd_s;
  logic [LINEAR_BITS-1:0] rd_m;
  logic [LINEAR_BITS-1:0] rd_l;

  // Stage 2: gain scaling
  logic [LINEAR_BITS-1:0] lin_s;
  logic [LINEAR_BITS-1:0] lin_m;
  logic [LINEAR_BITS-1:0] lin_l;
  logic [PROD_BITS-1:0]   prod_m;
  logic [PROD_BITS-1:0]   prod_l;
  logic                   s2_valid;
  logic                   s2_long_ok;
  logic                   s2_mid_ok;
  logic [LINEAR_BITS-1:0] s2_ls;
  logic [LINEAR_BITS-1:0] s2_sm;
  logic [LINEAR_BITS-1:0] s2_sl;

  // Stage 3: selection
  logic [SUM_BITS-1:0]    sum3;
  logic [LINEAR_BITS:0]   sum2;
  logic                   use_div_next;
  logic [LINEAR_BITS-1:0] direct_next;
  source_t                src_next;
  logic                   s3_valid;
  logic                   s3_use_div;
  logic [SUM_BITS-1:0]    s3_y;
  logic [LINEAR_BITS-1:0] s3_direct;
  source_t                s3_src;

  // Stage 4: divide by three
  logic                      s4_valid;
  logic                      s4_use_div;
  logic [DIV3_PROD_BITS-1:0] s4_prod;
  logic [LINEAR_BITS-1:0]    s4_direct;
  source_t                   s4_src;

  assign adv   = !(out_valid && out_stall);
  assign pop   = not_empty && adv;
  assign wr_en = pop && head.is_load && head.ch_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_s[head.addr_s] <= head.value;
    end
    if (adv) begin
      rd_s <= mem_s[head.addr_s];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_m[head.addr_s] <= head.value;
    end
    if (adv) begin
      rd_m <= mem_m[head.addr_m];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_l[head.addr_s] <= head.value;
    end
    if (adv) begin
      rd_l <= mem_l[head.addr_l];
    end
  end

  always_comb begin
    lin_s  = s1_ch_ok ? rd_s : '0;
    lin_m  = s1_ch_ok ? rd_m : '0;
    lin_l  = s1_ch_ok ? rd_l : '0;
    prod_m = PROD_BITS'(lin_m) * PROD_BITS'(cfg.gain_mid) + GAIN_ROUND;
    prod_l = PROD_BITS'(lin_l) * PROD_BITS'(cfg.gain_long) + GAIN_ROUND;
  end

  always_comb begin
    sum3 = SUM_BITS'(s2_ls) + SUM_BITS'(s2_sm) + SUM_BITS'(s2_sl) + SUM_BITS'(1);
    sum2 = (LINEAR_BITS + 1)'(s2_ls) + (LINEAR_BITS + 1)'(s2_sm) + (LINEAR_BITS + 1)'(1);
    use_div_next = 1'b0;
    if (s2_long_ok) begin
      src_next     = SRC_LONG;
      use_div_next = (cfg.merge_mode == MODE_AVERAGE);
      direct_next  = s2_sl;
    end else if (s2_mid_ok) begin
      src_next    = SRC_MID;
      direct_next = (cfg.merge_mode == MODE_AVERAGE) ? sum2[LINEAR_BITS:1] : s2_sm;
    end else begin
      src_next    = SRC_SHORT;
      direct_next = s2_ls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= pop && !head.is_load;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ch_ok   <= head.ch_ok;
      s1_long_ok <= head.long_ok;
      s1_mid_ok  <= head.mid_ok;

      s2_long_ok <= s1_long_ok;
      s2_mid_ok  <= s1_mid_ok;
      s2_ls      <= lin_s;
      s2_sm      <= prod_m[GAIN_FRAC +: LINEAR_BITS];
      s2_sl      <= prod_l[GAIN_FRAC +: LINEAR_BITS];

      s3_use_div <= use_div_next;
      s3_y       <= sum3;
      s3_direct  <= direct_next;
      s3_src     <= src_next;

      s4_use_div <= s3_use_div;
      s4_prod    <= DIV3_PROD_BITS'(s3_y) * DIV3_PROD_BITS'(DIV3_RECIP);
      s4_direct  <= s3_direct;
      s4_src     <= s3_src;

      radiance   <= s4_use_div ? s4_prod[DIV3_SHIFT +: LINEAR_BITS] : s4_direct;
      source     <= s4_src;
    end
  end

endmodule

// ===== rtl/hdr_exposure_merge.sv =====
// Top level of the three-exposure HDR radiance merge.
// Throughput: one item per cycle unless the output stalls; the single pipelined
//   merge path with one read port per table copy sets that figure.
//   Load items give no result. Path: queue, table read, gain, select, divide, output.
// Reset: clears queue, pipeline valids and config registers; table contents
//   stay undefined until loaded (no clearing pass).
module hdr_exposure_merge (
  input  logic                             clk,
  input  logic                             rst,
  // input item channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             op,
  input  logic [hem_pkg::CHANNEL_BITS-1:0] channel,
  input  logic [hem_pkg::SAMPLE_BITS-1:0]  table_index,
  input  logic [hem_pkg::LINEAR_BITS-1:0]  table_value,
  input  logic [hem_pkg::SAMPLE_BITS-1:0]  sample_short,
  input  logic [hem_pkg::SAMPLE_BITS-1:0]  sample_mid,
  input  logic [hem_pkg::SAMPLE_BITS-1:0]  sample_long,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [hem_pkg::LINEAR_BITS-1:0]  radiance,
  output logic [1:0]                       source,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hem_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [hem_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import hem_pkg::*;

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t head;
  logic q_full;
  logic q_not_empty;
  logic push;
  logic pop;

  // Config writes are always accepted; cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.merge_mode <= MODE_PICK;
      cfg.gain_mid   <= GAIN_RESET;
      cfg.gain_long  <= GAIN_RESET;
      cfg.sat_level  <= SAT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_MERGE_MODE: cfg.merge_mode <= mode_t'(cfg_data[0]);
        CFG_GAIN_MID:   cfg.gain_mid   <= cfg_data[GAIN_BITS-1:0];
        CFG_GAIN_LONG:  cfg.gain_long  <= cfg_data[GAIN_BITS-1:0];
        CFG_SAT_LEVEL:  cfg.sat_level  <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Front end: classify the beat and compute table addresses and saturation flags.
  hem_front u_front (
    .op           (op),
    .channel      (channel),
    .table_index  (table_index),
    .table_value  (table_value),
    .sample_short (sample_short),
    .sample_mid   (sample_mid),
    .sample_long  (sample_long),
    .cfg          (cfg),
    .cmd          (front_cmd)
  );

  // Hold off the input only when the queue is full; a stalled result does not
  // block new beats until the queue fills behind it.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  hem_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cmd),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Back end: loads write the table; merges run the pipeline and produce a beat.
  hem_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .not_empty (q_not_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .radiance  (radiance),
    .source    (source)
  );

endmodule

// ===== rtl/hem_checker.sv =====
// Port-level checker for the HDR exposure merge, bound to the top level.
module hem_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [hem_pkg::LINEAR_BITS-1:0] radiance,
  input logic [1:0]                      source
);
  import hem_pkg::*;

  // Reset empties the queue and the pipeline.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("reset did not clear out_valid or in_stall");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(radiance) && $stable(source)))
    else $error("stalled result changed");

  // Only the three defined source codes are produced.
  a_source_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((source == SRC_SHORT) || (source == SRC_MID) || (source == SRC_LONG)))
    else $error("invalid source code");

  // The queue fills only through an accepted beat.
  a_stall_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("in_stall rose without an accepted beat");

  // With the output moving, a full queue drains by one.
  a_stall_drain: assert property (@(posedge clk) disable iff (rst)
    (in_stall && !(out_valid && out_stall)) |=> !in_stall)
    else $error("full queue did not drain while the output advanced");

endmodule

bind hdr_exposure_merge hem_checker u_hem_checker (.*);

// ===== dv/hdr_exposure_merge_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for hdr_exposure_merge: table loads, merges and register phases.
module hdr_exposure_merge_tb;
  import hem_pkg::*;

  localparam int NUM_PHASES      = 6;
  localparam int BEATS_PER_PHASE = 210;
  // Let loads that give no result retire before touching registers.
  localparam int DRAIN_CYCLES    = 12;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam logic [1:0]  NO_CHANNEL   = 2'd3;
  localparam logic [63:0] RADIANCE_MAX = (64'd1 << LINEAR_BITS) - 64'd1;

  // One input beat; the literal fields carry a hand-worked expectation for directed rows.
  typedef struct packed {
    op_t                    op;
    logic [1:0]             chan;
    logic [SAMPLE_BITS-1:0] code;
    logic [LINEAR_BITS-1:0] lin_value;
    logic [SAMPLE_BITS-1:0] raw_short;
    logic [SAMPLE_BITS-1:0] raw_mid;
    logic [SAMPLE_BITS-1:0] raw_long;
    logic                   has_literal;
    logic [LINEAR_BITS-1:0] lit_radiance;
    source_t                lit_source;
  } beat_t;

  typedef struct packed {
    logic [LINEAR_BITS-1:0] radiance;
    source_t                source;
  } merged_t;

  // Directed rows: extremes of table values and codes, every saturation outcome,
  // the ignored load to channel three, merges on channel three, and an overwrite
  // of an entry that is read back on the very next beat.
  localparam int NUM_DIRECTED = 23;
  localparam beat_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{OP_LOAD,  2'd0, 8'd0,   20'h00000, 8'd0,   8'd0,   8'd0,   1'b0, 20'h0,     SRC_SHORT},
    '{OP_LOAD,  2'd0, 8'd255, 20'hFFFFF, 8'd0,   8'd0,   8'd0,   1'b0, 20'h0,     SRC_SHORT},
    '{OP_LOAD,  2'd1, 8'd0,   20'hFFFFF, 8'd0,   8'd0,   8'd0,   1'b0, 20'h0,     SRC_SHORT},
    '{OP_LOAD,  2'd1, 8'd255, 20'h00000, 8'd0,   8'd0,   8'd0,   1'b0, 20'h0,     SRC_SHORT},
    '{OP_LOAD,  2'd2, 8'd0,   20'h55555, 8'd0,   8'd0,   8'd0,   1'b0, 20'h0,     SRC_SHORT},
    '{OP_LOAD,  2'd2, 8'd255, 20'hAAAAA, 8'd0,   8'd0,   8'd0,   1'b0, 20'h0,     SRC_SHORT},
    '{OP_LOAD,  2'd2, 8'd128, 20'h80000, 8'd0,   8'd0,   8'd0,   1'b0, 20'h0,     SRC_SHORT},
    '{OP_LOAD,  2'd1, 8'd127, 20'h7FFFF, 8'd0,   8'd0,   8'd0,   1'b0, 20'h0,     SRC_SHORT},
    '{OP_LOAD,  2'd3, 8'd7,   20'hFFFFF, 8'd0,   8'd0,   8'd0,   1'b0, 20'h0,     SRC_SHORT},
    '{OP_MERGE, 2'd0, 8'd0,   20'h00000, 8'd255, 8'd255, 8'd255, 1'b1, 20'hFFFFF, SRC_SHORT},
    '{OP_MERGE, 2'd0, 8'd0,   20'h00000, 8'd0,   8'd0,   8'd0,   1'b1, 20'h00000, SRC_LONG},
    '{OP_MERGE, 2'd0, 8'd0,   20'h00000, 8'd0,   8'd0,   8'd255, 1'b1, 20'h00000, SRC_MID},
    '{OP_MERGE, 2'd1, 8'd0,   20'h00000, 8'd255, 8'd255, 8'd0,   1'b0, 20'h0,     SRC_SHORT},
    '{OP_MERGE, 2'd1, 8'd0,   20'h00000, 8'd0,   8'd0,   8'd255, 1'b0, 20'h0,     SRC_SHORT},
    '{OP_MERGE, 2'd1, 8'd0,   20'h00000, 8'd0,   8'd255, 8'd255, 1'b1, 20'hFFFFF, SRC_SHORT},
    '{OP_MERGE, 2'd2, 8'd0,   20'h00000, 8'd255, 8'd0,   8'd128, 1'b0, 20'h0,     SRC_SHORT},
    '{OP_MERGE, 2'd2, 8'd0,   20'h00000, 8'd0,   8'd128, 8'd255, 1'b0, 20'h0,     SRC_SHORT},
    '{OP_MERGE, 2'd2, 8'd0,   20'h00000, 8'd128, 8'd255, 8'd255, 1'b1, 20'h80000, SRC_SHORT},
    '{OP_MERGE, 2'd3, 8'd0,   20'h00000, 8'd7,   8'd7,   8'd7,   1'b1, 20'h00000, SRC_LONG},
    '{OP_MERGE, 2'd3, 8'd0,   20'h00000, 8'd255, 8'd255, 8'd255, 1'b1, 20'h00000, SRC_SHORT},
    '{OP_MERGE, 2'd3, 8'd0,   20'h00000, 8'd0,   8'd255, 8'd0,   1'b1, 20'h00000, SRC_LONG},
    '{OP_LOAD,  2'd0, 8'd255, 20'h12345, 8'd0,   8'd0,   8'd0,   1'b0, 20'h0,     SRC_SHORT},
    '{OP_MERGE, 2'd0, 8'd0,   20'h00000, 8'd255, 8'd255, 8'd255, 1'b1, 20'h12345, SRC_SHORT}
  };

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic                      op;
  logic [CHANNEL_BITS-1:0]   channel;
  logic [SAMPLE_BITS-1:0]    table_index;
  logic [LINEAR_BITS-1:0]    table_value;
  logic [SAMPLE_BITS-1:0]    sample_short;
  logic [SAMPLE_BITS-1:0]    sample_mid;
  logic [SAMPLE_BITS-1:0]    sample_long;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [LINEAR_BITS-1:0]    radiance;
  logic [1:0]                source;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  // Shadow of the block: linear tables, which entries hold a value, and the registers.
  logic [LINEAR_BITS-1:0] lut_copy    [NUM_CHANNELS][CODES];
  bit                     written_map [NUM_CHANNELS][CODES];
  mode_t                  mode_r;
  logic [GAIN_BITS-1:0]   gain_mid_r;
  logic [GAIN_BITS-1:0]   gain_long_r;
  logic [SAMPLE_BITS-1:0] sat_r;
  logic [1:0]             last_load_ch;
  logic [SAMPLE_BITS-1:0] last_load_code;

  merged_t pending_merges [$];
  int      mismatches  = 0;
  int      beats_sent  = 0;
  int      stall_left  = 0;
  int      cycle_count = 0;
  int      idle_count  = 0;

  hdr_exposure_merge DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .channel      (channel),
    .table_index  (table_index),
    .table_value  (table_value),
    .sample_short (sample_short),
    .sample_mid   (sample_mid),
    .sample_long  (sample_long),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .radiance     (radiance),
    .source       (source),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle length for one beat; quiet windows give back-to-back stretches.
  function automatic int idle_cycles(bit quiet);
    if (quiet) return 0;
    return $urandom_range(0, 9);
  endfunction

  // Linear value of a raw code; channel three reads as zero.
  function automatic logic [63:0] lin_value_of(logic [1:0] ch, logic [SAMPLE_BITS-1:0] code);
    if (ch == NO_CHANNEL) return 64'd0;
    return 64'(lut_copy[ch][code]);
  endfunction

  // Bring a linear value to the short-exposure scale, round half up.
  function automatic logic [63:0] to_short_scale(logic [63:0] lin, logic [GAIN_BITS-1:0] gain);
    return (lin * 64'(gain) + 64'h8000) >> GAIN_FRAC;
  endfunction

  function automatic merged_t predict_merge(logic [1:0] ch, logic [SAMPLE_BITS-1:0] rs,
                                            logic [SAMPLE_BITS-1:0] rm,
                                            logic [SAMPLE_BITS-1:0] rl);
    logic [63:0] ls, sm, sl, acc;
    merged_t     r;
    ls = lin_value_of(ch, rs);
    sm = to_short_scale(lin_value_of(ch, rm), gain_mid_r);
    sl = to_short_scale(lin_value_of(ch, rl), gain_long_r);
    if (rl < sat_r) begin
      r.source = SRC_LONG;
      // Three-way average rounded to nearest.
      acc = (mode_r == MODE_PICK) ? sl : (64'd2 * (ls + sm + sl) + 64'd3) / 64'd6;
    end else if (rm < sat_r) begin
      r.source = SRC_MID;
      acc = (mode_r == MODE_PICK) ? sm : (ls + sm + 64'd1) >> 1;
    end else begin
      r.source = SRC_SHORT;
      acc = ls;
    end
    r.radiance = (acc > RADIANCE_MAX) ? '1 : acc[LINEAR_BITS-1:0];
    return r;
  endfunction

  // Pick a raw code whose entry holds a value; favor the entry loaded last.
  function automatic logic [SAMPLE_BITS-1:0] written_code(logic [1:0] ch);
    logic [SAMPLE_BITS-1:0] c;
    if (ch == last_load_ch && $urandom_range(0, 3) == 0) return last_load_code;
    do c = SAMPLE_BITS'($urandom); while (!written_map[ch][c]);
    return c;
  endfunction

  // Drive one beat, hold it through any stall, then update the shadow and
  // queue the expected merge at the accepting edge.
  task automatic send_beat(beat_t b);
    int      gap;
    merged_t m;
    gap = idle_cycles(((beats_sent / 48) % 4) == 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= b.op;
    channel      <= b.chan;
    table_index  <= b.code;
    table_value  <= b.lin_value;
    sample_short <= b.raw_short;
    sample_mid   <= b.raw_mid;
    sample_long  <= b.raw_long;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (b.op == OP_LOAD) begin
      // Loads to channel three are dropped by the block.
      if (b.chan != NO_CHANNEL) begin
        lut_copy[b.chan][b.code]    = b.lin_value;
        written_map[b.chan][b.code] = 1'b1;
        last_load_ch   = b.chan;
        last_load_code = b.code;
      end
    end else begin
      if (b.has_literal) begin
        m.radiance = b.lit_radiance;
        m.source   = b.lit_source;
      end else begin
        m = predict_merge(b.chan, b.raw_short, b.raw_mid, b.raw_long);
      end
      pending_merges.insert(pending_merges.size(), m);
    end
  endtask

  // Write all four registers in index order; valid stays up across back-to-back beats.
  task automatic program_regs(logic [CFG_DATA_BITS-1:0] mode_d, logic [CFG_DATA_BITS-1:0] gm_d,
                              logic [CFG_DATA_BITS-1:0] gl_d, logic [CFG_DATA_BITS-1:0] sat_d);
    logic [CFG_DATA_BITS-1:0] data [4];
    cfg_index_t               idx;
    data = '{mode_d, gm_d, gl_d, sat_d};
    for (int i = 0; i < 4; i++) begin
      idx = cfg_index_t'(i);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= data[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx)
        CFG_MERGE_MODE: mode_r      = mode_t'(data[i][0]);
        CFG_GAIN_MID:   gain_mid_r  = data[i][GAIN_BITS-1:0];
        CFG_GAIN_LONG:  gain_long_r = data[i][GAIN_BITS-1:0];
        CFG_SAT_LEVEL:  sat_r       = data[i][SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every queued merge, then let trailing loads retire.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_merges.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: check each accepted beat against the oldest expectation and
  // draw a fresh stall run after it; some windows run without stalls.
  always @(posedge clk) begin
    merged_t want;
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_merges.size() == 0) begin
          $display("%0t: result with nothing expected: radiance %h source %0d",
                   $time, radiance, source);
          mismatches++;
        end else begin
          want = pending_merges.pop_front();
          if (radiance !== want.radiance || source !== want.source) begin
            $display("%0t: mismatch: expected radiance %h source %0d, got radiance %h source %0d",
                     $time, want.radiance, want.source, radiance, source);
            mismatches++;
          end
        end
        stall_left = idle_cycles(((cycle_count / 300) % 4) == 1);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog: end the run when no channel moves a beat for too long.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("hdr_exposure_merge_tb: done, errors");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    beat_t b;
    int    pick;
    rst          = 1'b1;
    in_valid     = 1'b0;
    op           = OP_LOAD;
    channel      = '0;
    table_index  = '0;
    table_value  = '0;
    sample_short = '0;
    sample_mid   = '0;
    sample_long  = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    mode_r       = MODE_PICK;
    gain_mid_r   = GAIN_RESET;
    gain_long_r  = GAIN_RESET;
    sat_r        = SAT_RESET;
    last_load_ch   = NO_CHANNEL;
    last_load_code = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed rows run under the reset register values.
    foreach (DIRECTED_ROWS[i]) send_beat(DIRECTED_ROWS[i]);
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Fixed extremes first, then fully random register words (upper bits included).
      case (ph)
        0: program_regs(16'(MODE_AVERAGE), 16'hFFFF, 16'hFFFF, 16'h00FF);
        1: program_regs(16'(MODE_PICK),    16'h0000, 16'h0000, 16'h0080);
        2: program_regs(16'(MODE_AVERAGE), 16'h8000, 16'h0000, 16'h0000);
        default: program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      for (int k = 0; k < BEATS_PER_PHASE; k++) begin
        // Fields that the operation ignores carry noise.
        b              = '0;
        b.code         = SAMPLE_BITS'($urandom);
        b.lin_value    = LINEAR_BITS'($urandom);
        b.raw_short    = SAMPLE_BITS'($urandom);
        b.raw_mid      = SAMPLE_BITS'($urandom);
        b.raw_long     = SAMPLE_BITS'($urandom);
        if ($urandom_range(0, 99) < 35) begin
          b.op   = OP_LOAD;
          b.chan = ($urandom_range(0, 19) == 0) ? NO_CHANNEL : 2'($urandom_range(0, 2));
          pick   = $urandom_range(0, 9);
          if (pick == 0) b.lin_value = '0;
          else if (pick == 1) b.lin_value = '1;
        end else begin
          b.op = OP_MERGE;
          if ($urandom_range(0, 19) == 0) begin
            b.chan = NO_CHANNEL;
          end else begin
            // Lean on the channel just loaded to hit read-after-write in the pipe.
            b.chan = (last_load_ch != NO_CHANNEL && $urandom_range(0, 2) == 0) ?
                     last_load_ch : 2'($urandom_range(0, 2));
            b.raw_short = written_code(b.chan);
            b.raw_mid   = written_code(b.chan);
            b.raw_long  = written_code(b.chan);
          end
        end
        send_beat(b);
      end
      drain_results();
    end

    if (mismatches == 0) begin
      $display("hdr_exposure_merge_tb: done, clean");
    end else begin
      $display("hdr_exposure_merge_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== hdr_exposure_merge.f =====
rtl/hem_pkg.sv
rtl/hem_front.sv
rtl/hem_queue.sv
rtl/hem_back.sv
rtl/hdr_exposure_merge.sv
rtl/hem_checker.sv
dv/hdr_exposure_merge_tb.sv
